@@ rtl/sfn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfn_pkg: shared definitions for the spectral flux novelty core
// Default sizes, smoothing weights and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package sfn_pkg;

   // default sizes
   localparam int MAX_BINS_DEF  = 128;
   localparam int MAG_WIDTH_DEF = 16;

   // port field widths
   localparam int IN_MAG_W  = 16;
   localparam int NOVELTY_W = 16;
   localparam int BINS_W    = 8;

   // smoothing weights, Q0.16 (sum is exactly 1.0)
   localparam logic [15:0] W_NEW = 16'd45875;
   localparam logic [15:0] W_OLD = 16'd19661;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // take the input beat, read the stored bin
      logic calc;      // form the flux term and the weighted products
      logic update;    // write the bin back, accumulate, advance position
      logic div_init;  // load the divider, restart the frame
      logic div_step;  // one quotient bit
      logic emit;      // load the result register
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic last;      // captured beat closes the frame
      logic div_done;  // all quotient bits formed
      logic out_busy;  // result register cannot take a new result
   } stat_type;

endpackage

@@ rtl/sfn_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfn_ctrl: sequencer for the spectral flux novelty core
// Walks each bin through read, compute and write-back, then runs the
// end-of-frame division and hands the result to the output register.
// ----------------------------------------------------------------------------
module sfn_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  sfn_pkg::stat_type stat,
   output sfn_pkg::cmd_type  cmd
);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_CALC     = 6'b000010,
      ST_WRITE    = 6'b000100,
      ST_DIV_INIT = 6'b001000,
      ST_DIV      = 6'b010000,
      ST_EMIT     = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.update = 1'b1;
            state_in   = stat.last ? ST_DIV_INIT : ST_IDLE;
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            if (stat.div_done) begin
               state_in = ST_EMIT;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_EMIT: begin
            if (!stat.out_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/sfn_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfn_datapath: bin store, flux accumulator, divider and result register
// Stored bins are a memory; a fill mark stands in for clearing it, since
// every frame writes bins from index zero upward.
// ----------------------------------------------------------------------------
module sfn_datapath #(
   parameter int MAX_BINS  = sfn_pkg::MAX_BINS_DEF,
   parameter int MAG_WIDTH = sfn_pkg::MAG_WIDTH_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic [sfn_pkg::IN_MAG_W-1:0]              in_mag,
   input  logic                                      in_last,
   input  sfn_pkg::cmd_type                          cmd,
   output sfn_pkg::stat_type                         stat,
   input  logic                                      out_ready,
   output logic                                      out_valid,
   output logic [sfn_pkg::NOVELTY_W-1:0]             out_novelty,
   output logic [sfn_pkg::BINS_W-1:0]                out_count
);

   localparam int IDX_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int CNT_W  = $clog2(MAX_BINS + 1);
   localparam int SUM_W  = MAG_WIDTH + $clog2(MAX_BINS);
   localparam int STEP_W = $clog2(SUM_W + 1);
   localparam int PROD_W = MAG_WIDTH + 16;
   localparam int NOV_EXT_W = (SUM_W > sfn_pkg::NOVELTY_W) ? SUM_W : sfn_pkg::NOVELTY_W;
   localparam int BIN_EXT_W = (CNT_W > sfn_pkg::BINS_W) ? CNT_W : sfn_pkg::BINS_W;

   logic [MAG_WIDTH-1:0] bin_mem [MAX_BINS];

   logic [MAG_WIDTH-1:0] mag_ff;
   logic                 last_ff;
   logic                 in_range_ff;
   logic [MAG_WIDTH-1:0] rd_data_ff;
   logic                 rd_valid_ff;
   logic [MAG_WIDTH-1:0] diff_ff;
   logic [PROD_W-1:0]    prod_new_ff, prod_old_ff;
   logic [CNT_W-1:0]     pos_ff, fill_ff;
   logic [SUM_W-1:0]     sum_ff;
   logic [SUM_W-1:0]     quot_ff;
   logic [CNT_W:0]       rem_ff;
   logic [CNT_W-1:0]     dsr_ff;
   logic [STEP_W-1:0]    step_ff;
   logic                 out_valid_ff;
   logic [sfn_pkg::NOVELTY_W-1:0] novelty_ff;
   logic [sfn_pkg::BINS_W-1:0]    bins_ff;

   logic [MAG_WIDTH-1:0] old_val;
   logic [PROD_W:0]      blend_sum;
   logic [MAG_WIDTH-1:0] blend;
   logic [CNT_W:0]       rem_shift;
   logic                 rem_ge;
   logic [NOV_EXT_W-1:0] quot_ext;
   logic [BIN_EXT_W-1:0] dsr_ext;
   logic [IDX_W-1:0]     pos_idx;

   assign pos_idx = pos_ff[IDX_W-1:0];

   // stored bin, or zero where this index was never written
   assign old_val = rd_valid_ff ? rd_data_ff : '0;

   // weighted blend of new and stored magnitude
   assign blend_sum = {1'b0, prod_new_ff} + {1'b0, prod_old_ff};
   assign blend     = blend_sum[MAG_WIDTH+15:16];

   // one restoring division step
   assign rem_shift = {rem_ff[CNT_W-1:0], quot_ff[SUM_W-1]};
   assign rem_ge    = rem_shift >= {1'b0, dsr_ff};

   // widen the quotient and bin count for saturation to their port widths
   assign quot_ext = NOV_EXT_W'(quot_ff);
   assign dsr_ext  = BIN_EXT_W'(dsr_ff);

   // capture beat and read stored bin
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mag_ff      <= MAG_WIDTH'(in_mag);
         last_ff     <= in_last;
         in_range_ff <= pos_ff < CNT_W'(MAX_BINS);
         rd_valid_ff <= pos_ff < fill_ff;
         rd_data_ff  <= bin_mem[pos_idx];
      end
   end

   // flux term and weighted products
   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         diff_ff     <= (mag_ff > old_val) ? mag_ff - old_val : '0;
         prod_new_ff <= PROD_W'(mag_ff) * PROD_W'(sfn_pkg::W_NEW);
         prod_old_ff <= PROD_W'(old_val) * PROD_W'(sfn_pkg::W_OLD);
      end
   end

   // write back the smoothed bin
   always_ff @(posedge clock) begin
      if (cmd.update && in_range_ff) begin
         bin_mem[pos_idx] <= blend;
      end
   end

   // frame position, fill mark and flux sum
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         fill_ff <= '0;
         sum_ff  <= '0;
      end else if (cmd.div_init) begin
         pos_ff <= '0;
         sum_ff <= '0;
      end else if (cmd.update && in_range_ff) begin
         pos_ff <= pos_ff + 1'b1;
         sum_ff <= sum_ff + SUM_W'(diff_ff);
         if (pos_ff >= fill_ff) begin
            fill_ff <= pos_ff + 1'b1;
         end
      end
   end

   // iterative divider: sum by bins used
   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         quot_ff <= sum_ff;
         rem_ff  <= '0;
         dsr_ff  <= (pos_ff == '0) ? CNT_W'(1) : pos_ff;
         step_ff <= '0;
      end else if (cmd.div_step) begin
         quot_ff <= {quot_ff[SUM_W-2:0], rem_ge};
         rem_ff  <= rem_ge ? rem_shift - {1'b0, dsr_ff} : rem_shift;
         step_ff <= step_ff + 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         novelty_ff <= (quot_ext > NOV_EXT_W'({sfn_pkg::NOVELTY_W{1'b1}})) ?
                       {sfn_pkg::NOVELTY_W{1'b1}} : quot_ext[sfn_pkg::NOVELTY_W-1:0];
         bins_ff    <= (dsr_ext > BIN_EXT_W'({sfn_pkg::BINS_W{1'b1}})) ?
                       {sfn_pkg::BINS_W{1'b1}} : dsr_ext[sfn_pkg::BINS_W-1:0];
      end
   end

   assign stat.last     = last_ff;
   assign stat.div_done = step_ff == STEP_W'(SUM_W);
   assign stat.out_busy = out_valid_ff & ~out_ready;

   assign out_valid   = out_valid_ff;
   assign out_novelty = novelty_ff;
   assign out_count   = bins_ff;

endmodule

@@ rtl/spectral_flux_novelty_core.sv @@
`timescale 1ns / 1ps
// Each bin beat passes through read, compute and write-back before the core takes
// the next one. A frame's last beat then goes through divider load, the divider
// and the emit state before rsp_tvalid rises; the quotient has SUM_W = MAG_WIDTH +
// clog2(MAX_BINS) bits (23 at the defaults), formed by the one-bit-per-cycle divider.
// The beat after a frame's last waits for all of this, and longer while a result is held.
// Reset: synchronous; clears position, sum and bin-store fill mark (all bins read zero).
// ----------------------------------------------------------------------------
// spectral_flux_novelty_core: spectral flux onset novelty
// Accumulates the positive flux of each bin over its smoothed history and
// returns the mean flux per frame with the number of bins counted.
// ----------------------------------------------------------------------------
module spectral_flux_novelty_core #(
   parameter int MAX_BINS  = sfn_pkg::MAX_BINS_DEF,
   parameter int MAG_WIDTH = sfn_pkg::MAG_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] bin_magnitude
   input  logic        req_tlast,   // frame_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [15:0] novelty, [23:16] bins_used
);

   sfn_pkg::cmd_type  cmd;
   sfn_pkg::stat_type stat;
   logic [sfn_pkg::NOVELTY_W-1:0] novelty;
   logic [sfn_pkg::BINS_W-1:0]    bins_used;

   // sequencer
   sfn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // datapath
   sfn_datapath #(
      .MAX_BINS  (MAX_BINS),
      .MAG_WIDTH (MAG_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .in_mag      (req_tdata),
      .in_last     (req_tlast),
      .cmd         (cmd),
      .stat        (stat),
      .out_ready   (rsp_tready),
      .out_valid   (rsp_tvalid),
      .out_novelty (novelty),
      .out_count   (bins_used)
   );

   assign rsp_tdata = {bins_used, novelty};

endmodule

@@ dv/tb_spectral_flux_novelty_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spectral_flux_novelty_core: self-checking bench for the flux novelty core
// Streams spectrum frames of random length and content into the core. Frames
// include single-bin frames, full frames and frames with bins past the bin
// limit. Both stream sides idle at random. A scoreboard tracks the smoothed
// bin history and predicts each frame's mean flux and bin count. Every
// result beat is compared with the oldest predicted frame result.
// ----------------------------------------------------------------------------
module tb_spectral_flux_novelty_core;

   localparam int BIN_LIMIT   = sfn_pkg::MAX_BINS_DEF;
   localparam int TARGET_BINS = 750;
   localparam int QUIET_LIMIT = 4000;
   localparam int DRAIN_WAIT  = 60;
   localparam int IDLE_PCT    = 27;

   typedef struct packed {
      logic [sfn_pkg::BINS_W-1:0]    bins_used;
      logic [sfn_pkg::NOVELTY_W-1:0] novelty;
   } frame_result_type;

   // Tracks the smoothed spectrum and predicts one result per closed frame
   class novelty_tracker_type;
      logic [sfn_pkg::IN_MAG_W-1:0] smooth_mem [BIN_LIMIT];
      int unsigned                  position;
      longint unsigned              flux_total;
      frame_result_type             expected_frames [$];
      int                           mismatch_count;

      function new();
         foreach (smooth_mem[i]) smooth_mem[i] = '0;
         position       = 0;
         flux_total     = 0;
         mismatch_count = 0;
      endfunction

      function int pending();
         return expected_frames.size();
      endfunction

      // Fold one accepted bin beat into the history; close the frame on tlast
      function void take_bin(logic [sfn_pkg::IN_MAG_W-1:0] mag, logic closes);
         logic [sfn_pkg::IN_MAG_W-1:0] prior;
         logic [31:0]                  blend;
         longint unsigned              divisor;
         longint unsigned              quot;
         frame_result_type             res;
         if (position < BIN_LIMIT) begin
            prior = smooth_mem[position];
            if (mag > prior)
               flux_total += mag - prior;
            blend = {16'b0, mag} * {16'b0, sfn_pkg::W_NEW} +
                    {16'b0, prior} * {16'b0, sfn_pkg::W_OLD};
            smooth_mem[position] = blend[31:16];
            position++;
         end
         if (closes) begin
            divisor = (position == 0) ? 1 : position;
            quot    = flux_total / divisor;
            if (quot > 65535)
               quot = 65535;
            if (divisor > 255)
               divisor = 255;
            res.novelty   = quot[sfn_pkg::NOVELTY_W-1:0];
            res.bins_used = divisor[sfn_pkg::BINS_W-1:0];
            expected_frames.push_back(res);
            position   = 0;
            flux_total = 0;
         end
      endfunction

      // Compare one result beat against the oldest predicted frame
      function void check_frame(logic [23:0] beat);
         frame_result_type want;
         frame_result_type got;
         got = beat;
         if (expected_frames.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected result beat novelty=%h bins=%0d",
                        $realtime, got.novelty, got.bins_used);
            return;
         end
         want = expected_frames.pop_front();
         if (got.novelty !== want.novelty || got.bins_used !== want.bins_used) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: result mismatch novelty exp=%h act=%h bins exp=%0d act=%0d",
                        $realtime, want.novelty, got.novelty, want.bins_used,
                        got.bins_used);
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   novelty_tracker_type tracker = new();
   int                  beats_sent  = 0;
   int                  quiet_cycles = 0;
   bit                  steady_window = 1'b0;

   spectral_flux_novelty_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Stall the result side at random outside the steady window
   always @(posedge clock) begin
      rsp_tready <= steady_window || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // Check result beats and count cycles without any handshake
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (rsp_tvalid && rsp_tready)
            tracker.check_frame(rsp_tdata);
      end
   end

   // Give up when the stream stops moving
   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("spectral_flux_novelty_core regression: fail");
      $finish;
   end

   function automatic logic [15:0] pick_magnitude();
      unique case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 255));
         1: return 16'hFF00 | 16'($urandom_range(0, 255));
         default: return 16'($urandom);
      endcase
   endfunction

   // Present one bin beat, with optional idle cycles ahead of it
   task automatic send_bin(input logic [15:0] mag, input logic closes);
      while (!steady_window && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= mag;
      req_tlast  <= closes;
      do @(posedge clock); while (!req_tready);
      tracker.take_bin(mag, closes);
      beats_sent++;
      steady_window = (beats_sent >= 350 && beats_sent < 500);
   endtask

   task automatic send_frame(input int len);
      for (int i = 0; i < len; i++)
         send_bin(pick_magnitude(), i == len - 1);
   endtask

   // Hold the input side until every predicted frame has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0)
         @(posedge clock);
   endtask

   initial begin
      int  len;
      int  pick;
      bit  paused_mid;
      paused_mid = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed frames: single-bin extremes, decay of history, mixed edges
      send_bin(16'hFFFF, 1'b1);
      send_bin(16'h0000, 1'b1);
      send_bin(16'hFFFF, 1'b1);
      send_bin(16'h0001, 1'b0);
      send_bin(16'hFFFF, 1'b0);
      send_bin(16'h8000, 1'b0);
      send_bin(16'h7FFF, 1'b1);
      send_bin(16'hAAAA, 1'b0);
      send_bin(16'h5555, 1'b0);
      send_bin(16'h0000, 1'b0);
      send_bin(16'hFFFF, 1'b0);
      send_bin(16'h0100, 1'b1);
      wait_drained();

      // Full frame, then a frame running past the bin limit
      send_frame(BIN_LIMIT);
      send_frame(BIN_LIMIT + 7);

      // Random frames, mostly short, some full or overlong
      while (beats_sent < TARGET_BINS) begin
         pick = $urandom_range(0, 99);
         if (pick < 3)
            len = BIN_LIMIT;
         else if (pick < 6)
            len = BIN_LIMIT + $urandom_range(1, 12);
         else if (pick < 20)
            len = 1;
         else
            len = $urandom_range(2, 20);
         send_frame(len);
         if (!paused_mid && beats_sent >= 550) begin
            wait_drained();
            paused_mid = 1'b1;
         end
      end
      req_tvalid <= 1'b0;

      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (tracker.mismatch_count == 0 && tracker.pending() == 0)
         $display("spectral_flux_novelty_core regression: pass");
      else
         $display("spectral_flux_novelty_core regression: fail");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/sfn_pkg.sv
rtl/sfn_ctrl.sv
rtl/sfn_datapath.sv
rtl/spectral_flux_novelty_core.sv
dv/tb_spectral_flux_novelty_core.sv
